>>> design/klk_pkg.sv
// ----------------------------------------------------------------------------
// klk_pkg: shared types and constants for the keypad password lock
// Beat layouts, configuration record, phase encoding, event codes and the
// keypad matrix to ASCII map.
// ----------------------------------------------------------------------------
package klk_pkg;

  // Number of characters in one code entry.
  localparam int CODE_LENGTH_DEFAULT = 4;

  // Event kinds carried by an input beat. Code 3 means nothing and is ignored.
  localparam logic [1:0] KIND_CARD = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result event codes.
  localparam logic [3:0] EV_NONE         = 4'd0;
  localparam logic [3:0] EV_CARD_OK      = 4'd1;
  localparam logic [3:0] EV_DIGIT        = 4'd2;
  localparam logic [3:0] EV_UNLOCKED     = 4'd3;
  localparam logic [3:0] EV_WRONG_RETRY  = 4'd4;
  localparam logic [3:0] EV_TIMEOUT_RETRY = 4'd5;
  localparam logic [3:0] EV_FROZEN       = 4'd6;
  localparam logic [3:0] EV_EXHAUSTED    = 4'd7;
  localparam logic [3:0] EV_LOCKOUT_OVER = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIN_CODE      = 2'd0;
  localparam logic [1:0] REG_MAX_TRIES     = 2'd1;
  localparam logic [1:0] REG_ENTRY_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_LOCKOUT       = 2'd3;

  // Configuration reset values ("1234", four tries, 10 s entry, 20 s lockout).
  localparam logic [31:0] PIN_CODE_RESET      = 32'h3132_3334;
  localparam logic [3:0]  MAX_TRIES_RESET     = 4'd4;
  localparam logic [7:0]  ENTRY_TIMEOUT_RESET = 8'd10;
  localparam logic [15:0] LOCKOUT_RESET       = 16'd20;

  // Saturation limits of the counters.
  localparam logic [3:0] TRIES_MAX   = 4'hF;
  localparam logic [7:0] SECONDS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ENTRY,
    PH_FROZEN
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] key_row;
    logic [1:0] key_column;
  } item_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [7:0] key_char;
    logic [3:0] tries_used;
    logic       red_light;
    logic       green_light;
  } result_t;

  typedef struct packed {
    logic [31:0] pin_code;
    logic [3:0]  max_tries;
    logic [7:0]  entry_timeout_seconds;
    logic [15:0] lockout_seconds;
  } cfg_t;

  // Keypad map, indexed by {row, column}: rows "BACD", "639#", "5280", "417*".
  localparam logic [7:0] KEYMAP [16] = '{
    8'd66, 8'd65, 8'd67, 8'd68,
    8'd54, 8'd51, 8'd57, 8'd35,
    8'd53, 8'd50, 8'd56, 8'd48,
    8'd52, 8'd49, 8'd55, 8'd42
  };

  function automatic logic [7:0] key_to_char(input logic [1:0] row, input logic [1:0] col);
    return KEYMAP[{row, col}];
  endfunction

endpackage

>>> design/keypad_password_lock.sv
// ----------------------------------------------------------------------------
// keypad_password_lock: card and keypad door lock controller
// A card beat opens a code entry, key beats supply characters from a 4x4
// matrix, tick beats count seconds for the entry timeout and the lockout.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                    Payload                 Direction
//   -------  ---------------------------  ----------------------  ---------
//   item     item_valid / item_ready      item (item_t)           in
//   result   result_valid / result_ready  result (result_t)       out
//   cfg      cfg_valid / cfg_ready        cfg_index, cfg_data     in
//
// Every input beat yields exactly one result beat. An accepted beat waits in
// the input register until the result register is empty or being drained,
// then moves into the result register, where the result beat is offered. One
// beat is accepted per cycle while item_ready is high.
// The path runs through an input register, the decision logic in klk_core,
// and a result register; the lock state updates as the result register loads.
// When the result side stalls, one beat waits in the input register and
// item_ready drops only while both registers are full and not drained.
// Reset is synchronous: it empties both registers, returns the lock to idle
// and reloads the configuration defaults. Configuration writes are always
// accepted, since cfg_ready is tied high.
//
module keypad_password_lock #(
  parameter int CODE_LENGTH = klk_pkg::CODE_LENGTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  klk_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output klk_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import klk_pkg::*;

  // Configuration registers.
  cfg_t cfg;

  // Input register stage.
  logic    a_valid;
  item_t   a_item;
  logic    b_load;
  result_t core_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_code              <= PIN_CODE_RESET;
      cfg.max_tries             <= MAX_TRIES_RESET;
      cfg.entry_timeout_seconds <= ENTRY_TIMEOUT_RESET;
      cfg.lockout_seconds       <= LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIN_CODE:      cfg.pin_code              <= cfg_data;
        REG_MAX_TRIES:     cfg.max_tries             <= cfg_data[3:0];
        REG_ENTRY_TIMEOUT: cfg.entry_timeout_seconds <= cfg_data[7:0];
        REG_LOCKOUT:       cfg.lockout_seconds       <= cfg_data[15:0];
      endcase
    end
  end

  // The result register loads whenever it is empty or being drained; the
  // input register then hands its beat on and can take a new one at once.
  assign b_load     = a_valid && (!result_valid || result_ready);
  assign item_ready = !a_valid || b_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      a_item <= item;
    end
  end

  klk_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (b_load),
    .item (a_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      result <= core_res;
    end
  end

`ifndef SYNTHESIS
  // Both registers are empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !a_valid && !result_valid)
    else $error("pipeline not empty after reset");

  // A beat held in the input register during a stall is not lost or altered.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    a_valid && !item_ready |=> a_valid && $stable(a_item))
    else $error("held input beat changed");

  // An unlock always shows green and never red.
  a_unlock_green: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_code == EV_UNLOCKED |-> result.green_light && !result.red_light)
    else $error("unlock without green light");

  // The two lights are never on together.
  a_lights_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.red_light && result.green_light))
    else $error("red and green lit together");
`endif

endmodule

>>> design/klk_core.sv
// ----------------------------------------------------------------------------
// klk_core: lock state and one-beat decision logic
// Holds the lock state, works out the result for the beat in the input
// register and commits the new state when the result register loads.
// ----------------------------------------------------------------------------
module klk_core #(
  parameter int CODE_LENGTH = klk_pkg::CODE_LENGTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  klk_pkg::item_t   item,
  input  klk_pkg::cfg_t    cfg,
  output klk_pkg::result_t res
);
  import klk_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  phase_t             phase, phase_next;
  logic [7:0]         entered_chars [CODE_LENGTH];
  logic [CNT_W-1:0]   chars_entered, chars_entered_next;
  logic [3:0]         tries_count, tries_count_next;
  logic [7:0]         entry_seconds, entry_seconds_next;
  logic [15:0]        lockout_remaining, lockout_remaining_next;
  logic               red_state, red_state_next;
  logic               green_state, green_state_next;
  logic               char_wr;

  logic [7:0] ch;
  logic       last_key;
  logic       match;
  logic [3:0] tries_inc;
  logic       limit_hit;
  logic [7:0] seconds_inc;
  logic       timed_out;
  logic       lockout_done;
  logic [3:0] event_code;

  assign ch           = key_to_char(item.key_row, item.key_column);
  assign last_key     = (chars_entered == CNT_W'(CODE_LENGTH - 1));
  assign tries_inc    = (tries_count == TRIES_MAX) ? TRIES_MAX : tries_count + 4'd1;
  assign limit_hit    = (tries_inc >= cfg.max_tries);
  assign seconds_inc  = (entry_seconds == SECONDS_MAX) ? SECONDS_MAX : entry_seconds + 8'd1;
  assign timed_out    = (seconds_inc >= cfg.entry_timeout_seconds);
  assign lockout_done = (lockout_remaining <= 16'd1);

  // Compare stored characters and the key now pressed against the code.
  // Positions beyond the four bytes of the code expect zero.
  always_comb begin
    logic [7:0] want;
    logic [7:0] got;
    match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (CODE_LENGTH - 1 - k > 3) begin
        want = 8'd0;
      end else begin
        want = cfg.pin_code[8 * (CODE_LENGTH - 1 - k) +: 8];
      end
      got = (k == CODE_LENGTH - 1) ? ch : entered_chars[k];
      if (got != want) begin
        match = 1'b0;
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (item.kind)
      KIND_CARD: begin
        if (phase == PH_IDLE) phase_next = PH_ENTRY;
      end
      KIND_KEY: begin
        if (phase == PH_ENTRY && last_key) begin
          if (match) begin
            phase_next = PH_IDLE;
          end else if (limit_hit) begin
            phase_next = PH_FROZEN;
          end
        end
      end
      KIND_TICK: begin
        if (phase == PH_ENTRY && timed_out && limit_hit) begin
          phase_next = PH_IDLE;
        end else if (phase == PH_FROZEN && lockout_done) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // Counters, lights and the event code.
  always_comb begin
    chars_entered_next     = chars_entered;
    tries_count_next       = tries_count;
    entry_seconds_next     = entry_seconds;
    lockout_remaining_next = lockout_remaining;
    red_state_next         = red_state;
    green_state_next       = green_state;
    char_wr                = 1'b0;
    event_code             = EV_NONE;
    res.key_char           = 8'd0;
    unique case (item.kind)
      KIND_CARD: begin
        if (phase == PH_IDLE) begin
          tries_count_next   = 4'd0;
          chars_entered_next = '0;
          entry_seconds_next = 8'd0;
          event_code         = EV_CARD_OK;
        end
      end
      KIND_KEY: begin
        if (phase == PH_ENTRY) begin
          res.key_char = ch;
          char_wr      = 1'b1;
          if (last_key) begin
            tries_count_next   = tries_inc;
            chars_entered_next = '0;
            entry_seconds_next = 8'd0;
            if (match) begin
              green_state_next = 1'b1;
              red_state_next   = 1'b0;
              event_code       = EV_UNLOCKED;
            end else begin
              red_state_next   = 1'b1;
              green_state_next = 1'b0;
              if (limit_hit) begin
                lockout_remaining_next = cfg.lockout_seconds;
                event_code             = EV_FROZEN;
              end else begin
                event_code = EV_WRONG_RETRY;
              end
            end
          end else begin
            chars_entered_next = chars_entered + CNT_W'(1);
            event_code         = EV_DIGIT;
          end
        end
      end
      KIND_TICK: begin
        if (phase == PH_ENTRY) begin
          entry_seconds_next = seconds_inc;
          if (timed_out) begin
            tries_count_next   = tries_inc;
            chars_entered_next = '0;
            entry_seconds_next = 8'd0;
            event_code         = limit_hit ? EV_EXHAUSTED : EV_TIMEOUT_RETRY;
          end
        end else if (phase == PH_FROZEN) begin
          if (lockout_done) begin
            lockout_remaining_next = 16'd0;
            event_code             = EV_LOCKOUT_OVER;
          end else begin
            lockout_remaining_next = lockout_remaining - 16'd1;
          end
        end
      end
      default: event_code = EV_NONE;
    endcase
    res.event_code  = event_code;
    res.tries_used  = tries_count_next;
    res.red_light   = red_state_next;
    res.green_light = green_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      chars_entered     <= '0;
      tries_count       <= 4'd0;
      entry_seconds     <= 8'd0;
      lockout_remaining <= 16'd0;
      red_state         <= 1'b0;
      green_state       <= 1'b0;
    end else if (en) begin
      phase             <= phase_next;
      chars_entered     <= chars_entered_next;
      tries_count       <= tries_count_next;
      entry_seconds     <= entry_seconds_next;
      lockout_remaining <= lockout_remaining_next;
      red_state         <= red_state_next;
      green_state       <= green_state_next;
    end
  end

  // Entered characters need no reset: each is written before it is compared.
  always_ff @(posedge clk) begin
    if (en && char_wr && !last_key) begin
      entered_chars[chars_entered[IDX_W-1:0]] <= ch;
    end
  end

endmodule
